@@ rtl/rbi_pkg.sv @@
// Package for the ray versus axis-aligned box test.
// Fixed point format, payload structs, axis and register codes.
// No dependencies.
package rbi_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DW         = 32;
    localparam int NUM_W      = DW + 1 + FRAC_BITS;
    localparam int HI_W       = NUM_W - DW;
    localparam int DIV_STAGES = DW;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [DW-1:0] fix_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_MIN_X = 3'd0,
        REG_BOX_MAX_X = 3'd1,
        REG_BOX_MIN_Y = 3'd2,
        REG_BOX_MAX_Y = 3'd3,
        REG_BOX_MIN_Z = 3'd4,
        REG_BOX_MAX_Z = 3'd5,
        REG_TOLERANCE = 3'd6,
        REG_UNUSED    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        fix_t start_x;
        fix_t start_y;
        fix_t start_z;
        fix_t dir_x;
        fix_t dir_y;
        fix_t dir_z;
    } ray_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] distance;
        fix_t        point_x;
        fix_t        point_y;
        fix_t        point_z;
        logic [1:0]  normal_axis;
        logic        normal_negative;
    } result_t;

endpackage

@@ rtl/rbi_ray_if.sv @@
// Ray input channel: valid/ready handshake with a ray_t payload.
// Depends on rbi_pkg.
interface rbi_ray_if;
    import rbi_pkg::*;
    logic valid;
    logic ready;
    ray_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rbi_result_if.sv @@
// Result output channel: valid/ready handshake with a result_t payload.
// Depends on rbi_pkg.
interface rbi_result_if;
    import rbi_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/rbi_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// Depends on rbi_pkg.
interface rbi_cfg_if;
    import rbi_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DW-1:0]        wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/ray_box_intersect.sv @@
// Ray versus axis-aligned box test, fully pipelined.
// Depends on rbi_pkg, rbi_ray_if, rbi_result_if, rbi_cfg_if.
//
// Channel   Dir   Payload
// cfg       in    index (3 bits), wdata (32 bits); always ready
// ray       in    start_x/y/z, dir_x/y/z, signed fixed point
// result    out   hit, distance, point_x/y/z, normal_axis, normal_negative
//
// One item enters per cycle unless the output stalls; the pipe is: input register, 32
// restoring divider stages (one quotient bit each, three axes in parallel),
// quotient saturation, max select, multiply, hit point, output register.
// Reset clears valid bits and loads the box registers with the unit cube.
// A stall at the output freezes the whole pipe; ray.ready drops with it.
module ray_box_intersect (
    input  logic         clk,
    input  logic         rst_n,
    rbi_cfg_if.sink      cfg,
    rbi_ray_if.sink      ray,
    rbi_result_if.source result
);
    import rbi_pkg::*;

    localparam fix_t FIX_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam fix_t FIX_MIN = {1'b1, {(DW-1){1'b0}}};

    // configuration registers
    fix_t              box_lo_reg [3];
    fix_t              box_hi_reg [3];
    logic [TOL_W-1:0]  tol_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                box_lo_reg[a] <= '0;
                box_hi_reg[a] <= fix_t'(1 << FRAC_BITS);
            end
            tol_reg <= TOL_W'(7);
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_BOX_MIN_X: box_lo_reg[0] <= cfg.wdata;
                REG_BOX_MAX_X: box_hi_reg[0] <= cfg.wdata;
                REG_BOX_MIN_Y: box_lo_reg[1] <= cfg.wdata;
                REG_BOX_MAX_Y: box_hi_reg[1] <= cfg.wdata;
                REG_BOX_MIN_Z: box_lo_reg[2] <= cfg.wdata;
                REG_BOX_MAX_Z: box_hi_reg[2] <= cfg.wdata;
                REG_TOLERANCE: tol_reg <= cfg.wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // global pipeline advance
    logic    out_valid_reg;
    result_t out_reg;
    logic    en;

    assign en           = !out_valid_reg || result.ready;
    assign ray.ready    = en;
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    function automatic fix_t start_of(ray_t r, int a);
        fix_t v;
        v = (a == 0) ? r.start_x : ((a == 1) ? r.start_y : r.start_z);
        return v;
    endfunction

    function automatic fix_t dir_of(ray_t r, int a);
        fix_t v;
        v = (a == 0) ? r.dir_x : ((a == 1) ? r.dir_y : r.dir_z);
        return v;
    endfunction

    // divider pipeline storage; index 0 is the input register
    logic          dv_valid_reg [DIV_STAGES+1];
    ray_t          dv_ray_reg   [DIV_STAGES+1];
    logic [DW-1:0] dv_rem_reg   [DIV_STAGES+1][3];
    logic [DW-1:0] dv_nq_reg    [DIV_STAGES+1][3];
    logic [DW-1:0] dv_dmag_reg  [DIV_STAGES+1][3];
    logic          dv_neg_reg   [DIV_STAGES+1][3];
    logic          dv_ov_reg    [DIV_STAGES+1][3];

    // input stage: numerator magnitude, divisor magnitude, overflow check
    logic [DW-1:0]  in_rem  [3];
    logic [DW-1:0]  in_nq   [3];
    logic [DW-1:0]  in_dmag [3];
    logic           in_neg  [3];
    logic           in_ov   [3];

    always_comb
    begin
        fix_t              s;
        fix_t              d;
        fix_t              plane;
        logic signed [DW:0] diff;
        logic [DW:0]       diff_mag;
        logic [NUM_W-1:0]  num_mag;
        for (int a = 0; a < 3; a++)
        begin
            s        = start_of(ray.data, a);
            d        = dir_of(ray.data, a);
            plane    = d[DW-1] ? box_hi_reg[a] : box_lo_reg[a];
            diff     = {plane[DW-1], plane} - {s[DW-1], s};
            diff_mag = diff[DW] ? (DW+1)'(-diff) : diff;
            num_mag  = {diff_mag, {FRAC_BITS{1'b0}}};
            in_dmag[a] = d[DW-1] ? DW'(-d) : d;
            in_neg[a]  = diff[DW] ^ d[DW-1];
            in_ov[a]   = {{(DW-HI_W){1'b0}}, num_mag[NUM_W-1:DW]} >= in_dmag[a];
            in_rem[a]  = {{(DW-HI_W){1'b0}}, num_mag[NUM_W-1:DW]};
            in_nq[a]   = num_mag[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (en)
            dv_valid_reg[0] <= ray.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_ray_reg[0] <= ray.data;
            for (int a = 0; a < 3; a++)
            begin
                dv_rem_reg[0][a]  <= in_rem[a];
                dv_nq_reg[0][a]   <= in_nq[a];
                dv_dmag_reg[0][a] <= in_dmag[a];
                dv_neg_reg[0][a]  <= in_neg[a];
                dv_ov_reg[0][a]   <= in_ov[a];
            end
        end
    end

    // restoring divider: one quotient bit per stage, shifted into nq
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (en)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            logic [DW:0] r2;
            if (en)
            begin
                dv_ray_reg[k+1] <= dv_ray_reg[k];
                for (int a = 0; a < 3; a++)
                begin
                    r2 = {dv_rem_reg[k][a], dv_nq_reg[k][a][DW-1]};
                    if (r2 >= {1'b0, dv_dmag_reg[k][a]})
                    begin
                        dv_rem_reg[k+1][a] <= DW'(r2 - {1'b0, dv_dmag_reg[k][a]});
                        dv_nq_reg[k+1][a]  <= {dv_nq_reg[k][a][DW-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[k+1][a] <= r2[DW-1:0];
                        dv_nq_reg[k+1][a]  <= {dv_nq_reg[k][a][DW-2:0], 1'b0};
                    end
                    dv_dmag_reg[k+1][a] <= dv_dmag_reg[k][a];
                    dv_neg_reg[k+1][a]  <= dv_neg_reg[k][a];
                    dv_ov_reg[k+1][a]   <= dv_ov_reg[k][a];
                end
            end
        end
    end

    // stage A: sign and saturate quotients
    logic  qa_valid_reg;
    ray_t  qa_ray_reg;
    fix_t  qa_q_reg  [3];
    logic  qa_nz_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qa_valid_reg <= 1'b0;
        else if (en)
            qa_valid_reg <= dv_valid_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        logic [DW-1:0] mag;
        if (en)
        begin
            qa_ray_reg <= dv_ray_reg[DIV_STAGES];
            for (int a = 0; a < 3; a++)
            begin
                mag = dv_nq_reg[DIV_STAGES][a];
                qa_nz_reg[a] <= dv_dmag_reg[DIV_STAGES][a] != '0;
                if (dv_neg_reg[DIV_STAGES][a])
                    qa_q_reg[a] <= (dv_ov_reg[DIV_STAGES][a] || mag > FIX_MIN)
                                   ? FIX_MIN : fix_t'(-mag);
                else
                    qa_q_reg[a] <= (dv_ov_reg[DIV_STAGES][a] || mag > FIX_MAX)
                                   ? FIX_MAX : fix_t'(mag);
            end
        end
    end

    // stage B: largest distance, ties to the lower axis; tolerance check
    logic          sb_valid_reg;
    ray_t          sb_ray_reg;
    fix_t          sb_t_reg;
    logic [1:0]    sb_axis_reg;
    logic          sb_miss_reg;
    fix_t          sel_t;
    logic [1:0]    sel_axis;
    logic          sel_found;

    always_comb
    begin
        sel_t     = '0;
        sel_axis  = AXIS_X;
        sel_found = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (qa_nz_reg[a] && (!sel_found || qa_q_reg[a] > sel_t))
            begin
                sel_t     = qa_q_reg[a];
                sel_axis  = 2'(a);
                sel_found = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sb_valid_reg <= 1'b0;
        else if (en)
            sb_valid_reg <= qa_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_ray_reg  <= qa_ray_reg;
            sb_t_reg    <= sel_t;
            sb_axis_reg <= sel_axis;
            sb_miss_reg <= !sel_found || sel_t < $signed({{(DW-TOL_W){1'b0}}, tol_reg});
        end
    end

    // stage C: dir times distance, one 32x32 product per axis
    logic                    mc_valid_reg;
    ray_t                    mc_ray_reg;
    fix_t                    mc_t_reg;
    logic [1:0]              mc_axis_reg;
    logic                    mc_miss_reg;
    logic signed [2*DW-1:0]  mc_prod_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mc_valid_reg <= 1'b0;
        else if (en)
            mc_valid_reg <= sb_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mc_ray_reg  <= sb_ray_reg;
            mc_t_reg    <= sb_t_reg;
            mc_axis_reg <= sb_axis_reg;
            mc_miss_reg <= sb_miss_reg;
            for (int a = 0; a < 3; a++)
                mc_prod_reg[a] <= (2*DW)'(dir_of(sb_ray_reg, a)) * (2*DW)'(sb_t_reg);
        end
    end

    // stage D: floor shift, add start, saturate
    logic       pd_valid_reg;
    ray_t       pd_ray_reg;
    fix_t       pd_t_reg;
    logic [1:0] pd_axis_reg;
    logic       pd_miss_reg;
    fix_t       pd_p_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pd_valid_reg <= 1'b0;
        else if (en)
            pd_valid_reg <= mc_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        logic signed [2*DW-1:0] sum;
        if (en)
        begin
            pd_ray_reg  <= mc_ray_reg;
            pd_t_reg    <= mc_t_reg;
            pd_axis_reg <= mc_axis_reg;
            pd_miss_reg <= mc_miss_reg;
            for (int a = 0; a < 3; a++)
            begin
                sum = (2*DW)'(start_of(mc_ray_reg, a)) + (mc_prod_reg[a] >>> FRAC_BITS);
                if (sum > (2*DW)'(FIX_MAX))
                    pd_p_reg[a] <= FIX_MAX;
                else if (sum < (2*DW)'(FIX_MIN))
                    pd_p_reg[a] <= FIX_MIN;
                else
                    pd_p_reg[a] <= sum[DW-1:0];
            end
        end
    end

    // stage E: face test and result
    logic    near_face [3];
    logic    in_range  [3];
    logic    face;
    logic    neg_sel;
    result_t res_next;

    always_comb
    begin
        logic signed [DW:0] dl;
        logic signed [DW:0] dh;
        logic [DW:0]        al;
        logic [DW:0]        ah;
        logic [DW:0]        tol_ext;
        tol_ext = {{(DW+1-TOL_W){1'b0}}, tol_reg};
        for (int a = 0; a < 3; a++)
        begin
            dl = {pd_p_reg[a][DW-1], pd_p_reg[a]} - {box_lo_reg[a][DW-1], box_lo_reg[a]};
            dh = {pd_p_reg[a][DW-1], pd_p_reg[a]} - {box_hi_reg[a][DW-1], box_hi_reg[a]};
            al = dl[DW] ? (DW+1)'(-dl) : dl;
            ah = dh[DW] ? (DW+1)'(-dh) : dh;
            near_face[a] = (al < tol_ext) || (ah < tol_ext);
            in_range[a]  = (box_lo_reg[a] <= pd_p_reg[a]) && (pd_p_reg[a] <= box_hi_reg[a]);
        end
        priority if (near_face[0])
            face = in_range[1] && in_range[2];
        else if (near_face[1])
            face = in_range[0] && in_range[2];
        else if (near_face[2])
            face = in_range[0] && in_range[1];
        else
            face = 1'b0;

        unique case (pd_axis_reg)
            AXIS_X:  neg_sel = !pd_ray_reg.dir_x[DW-1] || (box_hi_reg[0] == box_lo_reg[0]);
            AXIS_Y:  neg_sel = !pd_ray_reg.dir_y[DW-1] || (box_hi_reg[1] == box_lo_reg[1]);
            AXIS_Z:  neg_sel = !pd_ray_reg.dir_z[DW-1] || (box_hi_reg[2] == box_lo_reg[2]);
            default: neg_sel = 1'b0;
        endcase

        res_next = '0;
        if (!pd_miss_reg && face)
        begin
            res_next.hit             = 1'b1;
            res_next.distance        = pd_t_reg[30:0];
            res_next.point_x         = pd_p_reg[0];
            res_next.point_y         = pd_p_reg[1];
            res_next.point_z         = pd_p_reg[2];
            res_next.normal_axis     = pd_axis_reg;
            res_next.normal_negative = neg_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= pd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= res_next;
    end

`ifndef ASSERT_OFF
    a_hit_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.hit |-> out_reg.normal_axis != 2'd3)
        else $error("hit with invalid normal axis");

    a_hit_tol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.hit |->
            {1'b0, out_reg.distance} >= {{(DW-TOL_W){1'b0}}, tol_reg})
        else $error("hit distance below tolerance");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.hit |-> out_reg == '0)
        else $error("miss item carries nonzero fields");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(pd_valid_reg) && $stable(dv_valid_reg[0]))
        else $error("pipeline moved during stall");
`endif

endmodule

@@ dv/tb_ray_box_intersect.sv @@
// Testbench for ray_box_intersect: drives rays and box settings, predicts each
// result in SystemVerilog and checks every result item field by field.
// Depends on rbi_pkg, rbi_ray_if, rbi_result_if, rbi_cfg_if and the RTL.
module tb_ray_box_intersect;
    import rbi_pkg::*;

    localparam int LATENCY     = 38;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    rbi_cfg_if    cfg_ch();
    rbi_ray_if    ray_ch();
    rbi_result_if res_ch();

    ray_box_intersect i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch.sink),
        .ray    (ray_ch.sink),
        .result (res_ch.source)
    );

    // box and tolerance as the predictor sees them
    longint box_lo[3];
    longint box_hi[3];
    longint tol_q;

    ray_t    pending_rays[$];
    result_t expected_hits[$];
    int      errors;
    bit      quiet_phase;
    bit      hold_sink;
    int      src_gap;
    int      snk_gap;
    int      idle_cycles;
    bit      timed_out;
    bit      ray_took;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint sat_fix(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_frac(longint p);
        if (p >= 0)
            return p >>> FRAC_BITS;
        return -((-p - 1) >>> FRAC_BITS) - 1;
    endfunction

    function automatic longint gap_of(longint a, longint b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic bit in_span(longint v, longint lo, longint hi);
        return (lo <= v) && (v <= hi);
    endfunction

    // expected result of one ray against the current box
    function automatic result_t trace_ray(ray_t r);
        result_t res;
        longint  st[3];
        longint  dr[3];
        longint  pl[3];
        longint  pt[3];
        longint  t;
        longint  q;
        int      ax;
        bit      on_face;
        res = '0;
        t = 0;
        ax = -1;
        on_face = 1'b0;
        st[0] = r.start_x;
        st[1] = r.start_y;
        st[2] = r.start_z;
        dr[0] = r.dir_x;
        dr[1] = r.dir_y;
        dr[2] = r.dir_z;
        for (int a = 0; a < 3; a++)
        begin
            pl[a] = (dr[a] >= 0) ? box_lo[a] : box_hi[a];
            if (dr[a] != 0)
            begin
                q = sat_fix(((pl[a] - st[a]) * (64'sd1 << FRAC_BITS)) / dr[a]);
                if (ax < 0 || q > t)
                begin
                    t = q;
                    ax = a;
                end
            end
        end
        if (ax < 0 || t < tol_q)
            return res;
        for (int a = 0; a < 3; a++)
            pt[a] = sat_fix(st[a] + floor_frac(dr[a] * t));
        if (gap_of(pt[0], box_lo[0]) < tol_q || gap_of(pt[0], box_hi[0]) < tol_q)
            on_face = in_span(pt[1], box_lo[1], box_hi[1])
                   && in_span(pt[2], box_lo[2], box_hi[2]);
        else if (gap_of(pt[1], box_lo[1]) < tol_q || gap_of(pt[1], box_hi[1]) < tol_q)
            on_face = in_span(pt[0], box_lo[0], box_hi[0])
                   && in_span(pt[2], box_lo[2], box_hi[2]);
        else if (gap_of(pt[2], box_lo[2]) < tol_q || gap_of(pt[2], box_hi[2]) < tol_q)
            on_face = in_span(pt[0], box_lo[0], box_hi[0])
                   && in_span(pt[1], box_lo[1], box_hi[1]);
        if (!on_face)
            return res;
        res.hit             = 1'b1;
        res.distance        = t[30:0];
        res.point_x         = pt[0][31:0];
        res.point_y         = pt[1][31:0];
        res.point_z         = pt[2][31:0];
        res.normal_axis     = ax[1:0];
        res.normal_negative = (pl[ax] == box_lo[ax]);
        return res;
    endfunction

    // ray driver: random bursts of idling unless in the quiet phase
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ray_ch.valid <= 1'b0;
            ray_ch.data  <= '0;
            src_gap      <= 0;
        end
        else
        begin
            if (ray_took)
                void'(pending_rays.pop_front());
            if (src_gap > 0)
            begin
                ray_ch.valid <= 1'b0;
                src_gap      <= src_gap - 1;
            end
            else if (!(ray_ch.valid && !ray_took) && !quiet_phase
                     && $urandom_range(0, 19) == 0)
            begin
                ray_ch.valid <= 1'b0;
                src_gap      <= $urandom_range(0, 12);
            end
            else if (pending_rays.size() > 0)
            begin
                ray_ch.valid <= 1'b1;
                ray_ch.data  <= pending_rays[0];
            end
            else
                ray_ch.valid <= 1'b0;
        end
    end

    // result sink readiness: random bursts, plus a forced long hold
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            snk_gap      <= 0;
        end
        else if (hold_sink)
            res_ch.ready <= 1'b0;
        else if (snk_gap > 0)
        begin
            res_ch.ready <= 1'b0;
            snk_gap      <= snk_gap - 1;
        end
        else if (!quiet_phase && $urandom_range(0, 19) == 0)
        begin
            res_ch.ready <= 1'b0;
            snk_gap      <= $urandom_range(0, 12);
        end
        else
            res_ch.ready <= 1'b1;
    end

    // accepted rays get a prediction; results are compared on arrival
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            ray_took = ray_ch.valid && ray_ch.ready;
            if (ray_ch.valid && ray_ch.ready)
                expected_hits.push_back(trace_ray(ray_ch.data));
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result item %h", $time, res_ch.data);
                end
                else
                begin
                    result_t e;
                    result_t g;
                    e = expected_hits.pop_front();
                    g = res_ch.data;
                    if (g.hit !== e.hit || g.distance !== e.distance
                        || g.point_x !== e.point_x || g.point_y !== e.point_y
                        || g.point_z !== e.point_z || g.normal_axis !== e.normal_axis
                        || g.normal_negative !== e.normal_negative)
                    begin
                        errors++;
                        $display("%0t: mismatch exp hit=%b d=%h p=%h %h %h ax=%0d neg=%b",
                                 $time, e.hit, e.distance, e.point_x, e.point_y,
                                 e.point_z, e.normal_axis, e.normal_negative);
                        $display("%0t:          got hit=%b d=%h p=%h %h %h ax=%0d neg=%b",
                                 $time, g.hit, g.distance, g.point_x, g.point_y,
                                 g.point_z, g.normal_axis, g.normal_negative);
                    end
                end
            end
            if ((ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || hold_sink)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[ray_box_intersect] ERROR");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_BOX_MIN_X: box_lo[0] = longint'(signed'(val));
            REG_BOX_MAX_X: box_hi[0] = longint'(signed'(val));
            REG_BOX_MIN_Y: box_lo[1] = longint'(signed'(val));
            REG_BOX_MAX_Y: box_hi[1] = longint'(signed'(val));
            REG_BOX_MIN_Z: box_lo[2] = longint'(signed'(val));
            REG_BOX_MAX_Z: box_hi[2] = longint'(signed'(val));
            REG_TOLERANCE: tol_q = longint'(val[15:0]);
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_box(logic [31:0] lo, logic [31:0] hi, logic [15:0] tol);
        write_reg(REG_BOX_MIN_X, lo);
        write_reg(REG_BOX_MAX_X, hi);
        write_reg(REG_BOX_MIN_Y, lo);
        write_reg(REG_BOX_MAX_Y, hi);
        write_reg(REG_BOX_MIN_Z, lo);
        write_reg(REG_BOX_MAX_Z, hi);
        write_reg(REG_TOLERANCE, {16'd0, tol});
    endtask

    // block all traffic drained, then the pipe settles
    task automatic drain();
        while (pending_rays.size() > 0 || expected_hits.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 | $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 6 << 16)) - (2 << 16));
        endcase
    endfunction

    function automatic logic [31:0] rand_dir();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return $urandom();
            2: return 32'($signed($urandom_range(0, 3)) - 1);
            default: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
        endcase
    endfunction

    function automatic ray_t mk_ray(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                    logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        ray_t r;
        r.start_x = sx;
        r.start_y = sy;
        r.start_z = sz;
        r.dir_x   = dx;
        r.dir_y   = dy;
        r.dir_z   = dz;
        return r;
    endfunction

    // aimed ray: from a random nearby origin toward a random point of the box
    function automatic ray_t aimed_ray();
        longint tgt[3];
        longint org[3];
        for (int a = 0; a < 3; a++)
        begin
            tgt[a] = box_lo[a] + ((box_hi[a] - box_lo[a]) * $urandom_range(0, 256)) / 256;
            org[a] = tgt[a] - longint'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            org[a] = sat_fix(org[a]);
        end
        return mk_ray(org[0][31:0], org[1][31:0], org[2][31:0],
                      32'(tgt[0] - org[0]), 32'(tgt[1] - org[1]), 32'(tgt[2] - org[2]));
    endfunction

    task automatic push_random(int n);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 9) < 6)
                pending_rays.push_back(aimed_ray());
            else
                pending_rays.push_back(mk_ray(rand_coord(), rand_coord(), rand_coord(),
                                              rand_dir(), rand_dir(), rand_dir()));
    endtask

    initial
    begin
        errors       = 0;
        quiet_phase  = 1'b0;
        hold_sink    = 1'b0;
        timed_out    = 1'b0;
        ray_took     = 1'b0;
        idle_cycles  = 0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_BOX_MIN_X;
        cfg_ch.wdata = '0;
        ray_ch.valid = 1'b0;
        ray_ch.data  = '0;
        res_ch.ready = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = 0;
            box_hi[a] = 65536;
        end
        tol_q = 7;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rays against the reset unit cube
        pending_rays.push_back(mk_ray(-32'sd65536, 32'sd32768, 32'sd32768,
                                      32'sd65536, 0, 0));
        pending_rays.push_back(mk_ray(32'sd131072, 32'sd32768, 32'sd32768,
                                      -32'sd65536, 0, 0));
        pending_rays.push_back(mk_ray(32'sd32768, -32'sd65536, 32'sd32768,
                                      0, 32'sd65536, 0));
        pending_rays.push_back(mk_ray(32'sd32768, 32'sd131072, 32'sd32768,
                                      0, -32'sd65536, 0));
        pending_rays.push_back(mk_ray(32'sd32768, 32'sd32768, -32'sd65536,
                                      0, 0, 32'sd65536));
        pending_rays.push_back(mk_ray(32'sd32768, 32'sd32768, 32'sd131072,
                                      0, 0, -32'sd65536));
        // all directions zero, tie between axes, ray starting inside, miss
        pending_rays.push_back(mk_ray(0, 0, 0, 0, 0, 0));
        pending_rays.push_back(mk_ray(-32'sd65536, -32'sd65536, -32'sd65536,
                                      32'sd65536, 32'sd65536, 32'sd65536));
        pending_rays.push_back(mk_ray(32'sd32768, 32'sd32768, 32'sd32768,
                                      32'sd65536, 0, 0));
        pending_rays.push_back(mk_ray(-32'sd65536, 32'sd262144, 32'sd32768,
                                      32'sd65536, 0, 0));
        // field extremes, saturating quotients
        pending_rays.push_back(mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'sd1, 32'sd1, 32'sd1));
        pending_rays.push_back(mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      -32'sd1, -32'sd1, -32'sd1));
        pending_rays.push_back(mk_ray(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        pending_rays.push_back(mk_ray(32'h8000_0000, 32'h7FFF_FFFF, 0,
                                      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        drain();

        // flat box (min equals max), zero tolerance
        set_box(32'sd65536, 32'sd65536, 16'd0);
        pending_rays.push_back(mk_ray(0, 32'sd65536, 32'sd65536, 32'sd65536, 0, 0));
        drain();
        set_box(32'sd65536, 32'sd65536, 16'd7);
        pending_rays.push_back(mk_ray(0, 32'sd65536, 32'sd65536, 32'sd65536, 0, 0));
        pending_rays.push_back(mk_ray(32'sd131072, 32'sd65536, 32'sd65536,
                                      -32'sd65536, 0, 0));
        push_random(150);
        drain();

        // long receiver hold while rays keep coming, so the pipe backs up
        set_box(-32'sd131072, 32'sd196608, 16'd256);
        push_random(150);
        hold_sink = 1'b1;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
        drain();

        // extreme box and tolerance, inverted box
        set_box(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        push_random(200);
        drain();
        set_box(32'sd65536, 32'sd0, 16'd100);
        push_random(150);
        drain();

        // randomized boxes, final part without idling
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_BOX_MIN_X, $urandom_range(0, 4 << 16) - (2 << 16));
            write_reg(REG_BOX_MAX_X, 32'(box_lo[0] + $urandom_range(1, 4 << 16)));
            write_reg(REG_BOX_MIN_Y, $urandom_range(0, 4 << 16) - (2 << 16));
            write_reg(REG_BOX_MAX_Y, 32'(box_lo[1] + $urandom_range(1, 4 << 16)));
            write_reg(REG_BOX_MIN_Z, $urandom());
            write_reg(REG_BOX_MAX_Z, 32'(box_lo[2] + $urandom_range(1, 4 << 16)));
            write_reg(REG_TOLERANCE, $urandom_range(0, 2000));
            if (k == 3)
                quiet_phase = 1'b1;
            push_random(170);
            drain();
        end

        if (errors == 0)
            $display("[ray_box_intersect] OK");
        else
            $display("[ray_box_intersect] ERROR");
        $finish;
    end
endmodule
